// ===== rtl/gzmfc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the gzip member framing checker.
// No dependencies.
package gzmfc_pkg;

    typedef enum logic [7:0] {
        PH_FIXED   = 8'b0000_0001,
        PH_XLEN    = 8'b0000_0010,
        PH_XDATA   = 8'b0000_0100,
        PH_NAME    = 8'b0000_1000,
        PH_COMMENT = 8'b0001_0000,
        PH_HCRC    = 8'b0010_0000,
        PH_PAYLOAD = 8'b0100_0000,
        PH_CLOSED  = 8'b1000_0000
    } t_phase;

    typedef enum logic [1:0] {
        OP_MEMBER = 2'd0,
        OP_DATA   = 2'd1,
        OP_FINISH = 2'd2
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_val;
        logic       plast;
        logic [3:0] status;
        logic       lastr;
    } t_res;

    localparam logic [1:0] MODE_MEMBER = 2'd0;
    localparam logic [1:0] MODE_DATA   = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;

    localparam logic [1:0] CFG_LIMIT_ENABLE = 2'd0;
    localparam logic [1:0] CFG_OUTPUT_LIMIT = 2'd1;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_SMALL     = 4'd1;
    localparam logic [3:0] ST_MAGIC     = 4'd2;
    localparam logic [3:0] ST_METHOD    = 4'd3;
    localparam logic [3:0] ST_FLAGS     = 4'd4;
    localparam logic [3:0] ST_EXTRA     = 4'd5;
    localparam logic [3:0] ST_UNTERM    = 4'd6;
    localparam logic [3:0] ST_NOPAYLOAD = 4'd7;
    localparam logic [3:0] ST_CRC       = 4'd8;
    localparam logic [3:0] ST_SIZE      = 4'd9;
    localparam logic [3:0] ST_LIMIT     = 4'd10;

    localparam logic [7:0]  MAGIC0       = 8'h1f;
    localparam logic [7:0]  MAGIC1       = 8'h8b;
    localparam logic [7:0]  CM_DEFLATE   = 8'h08;
    localparam logic [7:0]  FLG_RESERVED = 8'he0;
    localparam logic [7:0]  FLG_EXTRA    = 8'h04;
    localparam logic [7:0]  FLG_NAME     = 8'h08;
    localparam logic [7:0]  FLG_COMMENT  = 8'h10;
    localparam logic [7:0]  FLG_HCRC     = 8'h02;
    localparam logic [31:0] CRC_POLY     = 32'hedb88320;
    localparam logic [31:0] CRC_INIT     = 32'hffffffff;
    localparam logic [31:0] MIN_MEMBER   = 32'd18;
    localparam logic [30:0] LIMIT_RESET  = 31'h7fffffff;
    localparam logic [3:0]  FIXED_LAST   = 4'd9;

    function automatic t_phase next_phase(input t_phase from, input logic [7:0] flags);
        logic b_x;
        logic b_n;
        logic b_c;
        t_phase p;
        b_x = (from == PH_FIXED);
        b_n = b_x || (from == PH_XLEN) || (from == PH_XDATA);
        b_c = b_n || (from == PH_NAME);
        if (b_x && (flags & FLG_EXTRA) != 8'd0) begin
            p = PH_XLEN;
        end else if (b_n && (flags & FLG_NAME) != 8'd0) begin
            p = PH_NAME;
        end else if (b_c && (flags & FLG_COMMENT) != 8'd0) begin
            p = PH_COMMENT;
        end else if ((flags & FLG_HCRC) != 8'd0) begin
            p = PH_HCRC;
        end else begin
            p = PH_PAYLOAD;
        end
        return p;
    endfunction

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

// ===== rtl/gzmfc_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input beats, decodes the mode and queues commands.
// Depends on gzmfc_pkg.
module gzmfc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_mode,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output logic              o_cmd_valid,
    output gzmfc_pkg::t_cmd   o_cmd,
    input  logic              i_cmd_pop
);

    gzmfc_pkg::t_cmd r_q [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic       push;
    logic       keep;
    gzmfc_pkg::t_op op;

    always_comb begin
        keep = 1'b1;
        op   = gzmfc_pkg::OP_MEMBER;
        unique case (i_mode)
            gzmfc_pkg::MODE_MEMBER: op = gzmfc_pkg::OP_MEMBER;
            gzmfc_pkg::MODE_DATA:   op = gzmfc_pkg::OP_DATA;
            gzmfc_pkg::MODE_FINISH: op = gzmfc_pkg::OP_FINISH;
            default:                keep = 1'b0;
        endcase
    end

    assign o_in_stall  = (r_cnt == 3'd4);
    assign push        = i_in_valid && !o_in_stall && keep;
    assign o_cmd_valid = (r_cnt != 3'd0);
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= '{op: op, data: i_data_byte, last: i_last_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (i_cmd_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_cnt <= r_cnt + {2'd0, push} - {2'd0, i_cmd_pop};
        end
    end

endmodule

// ===== rtl/gzmfc_back.sv =====
`timescale 1ns / 1ps
// Back end: header parser, trailer window, CRC-32, byte count and verdicts.
// Depends on gzmfc_pkg.
module gzmfc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [30:0]       i_cfg_data,
    input  logic              i_cmd_valid,
    input  gzmfc_pkg::t_cmd   i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_res_ready,
    output logic [1:0]        o_push_cnt,
    output gzmfc_pkg::t_res   o_res0,
    output gzmfc_pkg::t_res   o_res1
);

    logic              r_limit_en;
    logic [30:0]       r_limit;
    gzmfc_pkg::t_phase r_phase, n_phase;
    logic [3:0]        r_pos, n_pos;
    logic [7:0]        r_flags, n_flags;
    logic [15:0]       r_xrem, n_xrem;
    logic [7:0]        r_xlo, n_xlo;
    logic [31:0]       r_mcount, n_mcount;
    logic [7:0]        r_win [8];
    logic [7:0]        n_win [8];
    logic [3:0]        r_fill, n_fill;
    logic [3:0]        r_err, n_err;
    logic [31:0]       r_crc, n_crc;
    logic [31:0]       r_ocount, n_ocount;
    logic              r_over, n_over;

    logic       emitted;
    logic       latch_req;
    logic [3:0] latch_code;
    logic [3:0] st;
    logic [7:0] b;

    assign o_cmd_pop = i_cmd_valid && i_res_ready;
    assign b         = i_cmd.data;

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_flags    = r_flags;
        n_xrem     = r_xrem;
        n_xlo      = r_xlo;
        n_mcount   = r_mcount;
        n_win      = r_win;
        n_fill     = r_fill;
        n_err      = r_err;
        n_crc      = r_crc;
        n_ocount   = r_ocount;
        n_over     = r_over;
        emitted    = 1'b0;
        latch_req  = 1'b0;
        latch_code = gzmfc_pkg::ST_OK;
        st         = gzmfc_pkg::ST_OK;
        o_push_cnt = 2'd0;
        o_res0     = '0;
        o_res1     = '0;

        if (o_cmd_pop) begin
            case (i_cmd.op)
                gzmfc_pkg::OP_MEMBER: begin
                    if (r_mcount != 32'hffffffff) begin
                        n_mcount = r_mcount + 32'd1;
                    end
                    unique case (r_phase)
                        gzmfc_pkg::PH_FIXED: begin
                            if (r_pos == 4'd0 && b != gzmfc_pkg::MAGIC0) begin
                                latch_req  = 1'b1;
                                latch_code = gzmfc_pkg::ST_MAGIC;
                            end else if (r_pos == 4'd1 && b != gzmfc_pkg::MAGIC1) begin
                                latch_req  = 1'b1;
                                latch_code = gzmfc_pkg::ST_MAGIC;
                            end else if (r_pos == 4'd2 && b != gzmfc_pkg::CM_DEFLATE) begin
                                latch_req  = 1'b1;
                                latch_code = gzmfc_pkg::ST_METHOD;
                            end else begin
                                if (r_pos == 4'd3) begin
                                    n_flags = b;
                                end
                                if (r_pos == 4'd3 && (b & gzmfc_pkg::FLG_RESERVED) != 8'd0) begin
                                    latch_req  = 1'b1;
                                    latch_code = gzmfc_pkg::ST_FLAGS;
                                end else if (r_pos >= gzmfc_pkg::FIXED_LAST) begin
                                    n_phase = gzmfc_pkg::next_phase(gzmfc_pkg::PH_FIXED, r_flags);
                                    n_pos   = 4'd0;
                                end else begin
                                    n_pos = r_pos + 4'd1;
                                end
                            end
                        end
                        gzmfc_pkg::PH_XLEN: begin
                            if (r_pos == 4'd0) begin
                                n_xlo = b;
                                n_pos = 4'd1;
                            end else begin
                                n_xrem = {b, r_xlo};
                                n_pos  = 4'd0;
                                if ({b, r_xlo} == 16'd0) begin
                                    n_phase = gzmfc_pkg::next_phase(gzmfc_pkg::PH_XDATA, r_flags);
                                end else begin
                                    n_phase = gzmfc_pkg::PH_XDATA;
                                end
                            end
                        end
                        gzmfc_pkg::PH_XDATA: begin
                            n_xrem = r_xrem - 16'd1;
                            if (n_xrem == 16'd0) begin
                                n_phase = gzmfc_pkg::next_phase(gzmfc_pkg::PH_XDATA, r_flags);
                                n_pos   = 4'd0;
                            end
                        end
                        gzmfc_pkg::PH_NAME, gzmfc_pkg::PH_COMMENT: begin
                            if (b == 8'd0) begin
                                n_phase = gzmfc_pkg::next_phase(r_phase, r_flags);
                                n_pos   = 4'd0;
                            end
                        end
                        gzmfc_pkg::PH_HCRC: begin
                            if (r_pos == 4'd0) begin
                                n_pos = 4'd1;
                            end else begin
                                n_phase = gzmfc_pkg::PH_PAYLOAD;
                                n_pos   = 4'd0;
                            end
                        end
                        gzmfc_pkg::PH_PAYLOAD: begin
                            if (r_fill[3]) begin
                                emitted = 1'b1;
                                for (int i = 0; i < 7; i++) begin
                                    n_win[i] = r_win[i + 1];
                                end
                                n_win[7] = b;
                            end else begin
                                n_win[r_fill[2:0]] = b;
                                n_fill = r_fill + 4'd1;
                            end
                        end
                        default: begin
                        end
                    endcase

                    if (latch_req) begin
                        if (r_err == gzmfc_pkg::ST_OK) begin
                            n_err = latch_code;
                        end
                        n_phase = gzmfc_pkg::PH_CLOSED;
                        n_pos   = 4'd0;
                    end

                    if (!i_cmd.last) begin
                        if (emitted) begin
                            o_push_cnt = 2'd1;
                            o_res0 = '{kind: 1'b0, byte_val: r_win[0], plast: 1'b0,
                                       status: gzmfc_pkg::ST_OK, lastr: 1'b1};
                        end
                    end else begin
                        if (n_mcount < gzmfc_pkg::MIN_MEMBER) begin
                            st = gzmfc_pkg::ST_SMALL;
                        end else begin
                            unique case (n_phase)
                                gzmfc_pkg::PH_CLOSED:  st = n_err;
                                gzmfc_pkg::PH_FIXED:   st = gzmfc_pkg::ST_SMALL;
                                gzmfc_pkg::PH_XLEN,
                                gzmfc_pkg::PH_XDATA:   st = gzmfc_pkg::ST_EXTRA;
                                gzmfc_pkg::PH_NAME,
                                gzmfc_pkg::PH_COMMENT: st = gzmfc_pkg::ST_UNTERM;
                                gzmfc_pkg::PH_HCRC:    st = gzmfc_pkg::ST_NOPAYLOAD;
                                default: st = n_fill[3] ? gzmfc_pkg::ST_OK
                                                        : gzmfc_pkg::ST_NOPAYLOAD;
                            endcase
                        end
                        n_err   = st;
                        n_phase = gzmfc_pkg::PH_CLOSED;
                        n_pos   = 4'd0;
                        if (emitted) begin
                            o_push_cnt = 2'd2;
                            o_res0 = '{kind: 1'b0, byte_val: r_win[0], plast: 1'b1,
                                       status: gzmfc_pkg::ST_OK, lastr: 1'b0};
                            o_res1 = '{kind: 1'b1, byte_val: 8'd0, plast: 1'b0,
                                       status: st, lastr: 1'b1};
                        end else begin
                            o_push_cnt = 2'd1;
                            o_res0 = '{kind: 1'b1, byte_val: 8'd0, plast: 1'b0,
                                       status: st, lastr: 1'b1};
                        end
                    end
                end
                gzmfc_pkg::OP_DATA: begin
                    n_crc    = gzmfc_pkg::crc32_byte(r_crc, b);
                    n_ocount = r_ocount + 32'd1;
                    if (r_limit_en && n_ocount > {1'b0, r_limit}) begin
                        n_over = 1'b1;
                    end
                end
                gzmfc_pkg::OP_FINISH: begin
                    if (r_phase != gzmfc_pkg::PH_CLOSED) begin
                        st = gzmfc_pkg::ST_SMALL;
                    end else if (r_err != gzmfc_pkg::ST_OK) begin
                        st = r_err;
                    end else if (r_over) begin
                        st = gzmfc_pkg::ST_LIMIT;
                    end else if ((r_crc ^ gzmfc_pkg::CRC_INIT) !=
                                 {r_win[3], r_win[2], r_win[1], r_win[0]}) begin
                        st = gzmfc_pkg::ST_CRC;
                    end else if (r_ocount != {r_win[7], r_win[6], r_win[5], r_win[4]}) begin
                        st = gzmfc_pkg::ST_SIZE;
                    end else begin
                        st = gzmfc_pkg::ST_OK;
                    end
                    o_push_cnt = 2'd1;
                    o_res0 = '{kind: 1'b1, byte_val: 8'd0, plast: 1'b0,
                               status: st, lastr: 1'b1};
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_en <= 1'b0;
            r_limit    <= gzmfc_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gzmfc_pkg::CFG_LIMIT_ENABLE: r_limit_en <= i_cfg_data[0];
                gzmfc_pkg::CFG_OUTPUT_LIMIT: r_limit    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= gzmfc_pkg::PH_FIXED;
            r_pos    <= 4'd0;
            r_flags  <= 8'd0;
            r_xrem   <= 16'd0;
            r_xlo    <= 8'd0;
            r_mcount <= 32'd0;
            for (int i = 0; i < 8; i++) begin
                r_win[i] <= 8'd0;
            end
            r_fill   <= 4'd0;
            r_err    <= gzmfc_pkg::ST_OK;
            r_crc    <= gzmfc_pkg::CRC_INIT;
            r_ocount <= 32'd0;
            r_over   <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_flags  <= n_flags;
            r_xrem   <= n_xrem;
            r_xlo    <= n_xlo;
            r_mcount <= n_mcount;
            r_win    <= n_win;
            r_fill   <= n_fill;
            r_err    <= n_err;
            r_crc    <= n_crc;
            r_ocount <= n_ocount;
            r_over   <= n_over;
        end
    end

endmodule

// ===== rtl/gzmfc_res_q.sv =====
`timescale 1ns / 1ps
// Result queue: takes up to two results per cycle, hands out one beat per cycle when not stalled.
// Depends on gzmfc_pkg.
module gzmfc_res_q (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  gzmfc_pkg::t_res   i_res0,
    input  gzmfc_pkg::t_res   i_res1,
    output logic              o_ready,
    output logic              o_valid,
    output gzmfc_pkg::t_res   o_res,
    input  logic              i_stall
);

    gzmfc_pkg::t_res r_q [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic       pop;

    assign o_ready = (r_cnt <= 3'd2);
    assign o_valid = (r_cnt != 3'd0);
    assign o_res   = r_q[r_rd];
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_q[r_wr] <= i_res0;
        end
        if (i_push_cnt == 2'd2) begin
            r_q[r_wr + 2'd1] <= i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wr <= r_wr + i_push_cnt;
            if (pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_cnt <= r_cnt + {1'b0, i_push_cnt} - {2'd0, pop};
        end
    end

endmodule

// ===== rtl/gzip_member_framing_checker.sv =====
`timescale 1ns / 1ps
// Top level of the gzip member framing checker: front queue, checker core, result queue.
// Depends on gzmfc_pkg, gzmfc_front, gzmfc_back, gzmfc_res_q.
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------------
//  in      | i_in_valid / o_in_stall    | i_mode, i_data_byte, i_last_byte
//  out     | o_out_valid / i_out_stall  | o_kind, o_out_byte, o_payload_last,
//          |                            | o_status, o_last_result
//  cfg     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One input beat per cycle while o_in_stall is low; a result is registered in the front
// queue, then by the core into the result queue, before it is presented.
// The output side moves one result beat per cycle while i_out_stall is low, so a
// member's last byte with a payload result costs two out beats.
// Synchronous active-low reset empties both queues and restores the parser state.
// o_in_stall rises when the four-entry front queue is full; the core holds while the
// four-entry result queue has fewer than two free slots.
module gzip_member_framing_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_payload_last,
    output logic [3:0]  o_status,
    output logic        o_last_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data
);

    logic            cmd_valid;
    logic            cmd_pop;
    gzmfc_pkg::t_cmd cmd;
    logic            res_ready;
    logic [1:0]      push_cnt;
    gzmfc_pkg::t_res res0;
    gzmfc_pkg::t_res res1;
    gzmfc_pkg::t_res res_head;

    assign o_cfg_ready = 1'b1;

    gzmfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    gzmfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_ready (res_ready),
        .o_push_cnt  (push_cnt),
        .o_res0      (res0),
        .o_res1      (res1)
    );

    gzmfc_res_q u_res_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_res0     (res0),
        .i_res1     (res1),
        .o_ready    (res_ready),
        .o_valid    (o_out_valid),
        .o_res      (res_head),
        .i_stall    (i_out_stall)
    );

    assign o_kind         = res_head.kind;
    assign o_out_byte     = res_head.byte_val;
    assign o_payload_last = res_head.plast;
    assign o_status       = res_head.status;
    assign o_last_result  = res_head.lastr;

endmodule
